### rtl/core/dmhq_pkg.sv
// Package for the d-ary min-heap queue: entry type, status codes, FSM codes,
// the arity reciprocal table and the key compare. Depends on nothing.
package dmhq_pkg;

	typedef struct packed {
		logic [15:0]        tag;
		logic signed [31:0] key;
	} entry_t;

	localparam logic [1:0] ST_DONE  = 2'd0;
	localparam logic [1:0] ST_FULL  = 2'd1;
	localparam logic [1:0] ST_EMPTY = 2'd2;

	localparam logic signed [31:0] KEY_MAX = 32'sh7FFF_FFFF;

	// Quotient by the arity is taken as (x * RECIP) >> RECIP_SHIFT.
	// This is exact for x below 2**16 and arity up to 16.
	localparam int RECIP_SHIFT = 20;

	function automatic logic [20:0] arity_recip(input logic [4:0] d);
		logic [20:0] r;
		unique case (d)
			5'd3:    r = 21'd349526;
			5'd4:    r = 21'd262144;
			5'd5:    r = 21'd209716;
			5'd6:    r = 21'd174763;
			5'd7:    r = 21'd149797;
			5'd8:    r = 21'd131072;
			5'd9:    r = 21'd116509;
			5'd10:   r = 21'd104858;
			5'd11:   r = 21'd95326;
			5'd12:   r = 21'd87382;
			5'd13:   r = 21'd80660;
			5'd14:   r = 21'd74899;
			5'd15:   r = 21'd69906;
			5'd16:   r = 21'd65536;
			default: r = 21'd524288;
		endcase
		return r;
	endfunction

	function automatic logic key_less(input logic signed [31:0] a,
	                                  input logic signed [31:0] b);
		return a < b;
	endfunction

	localparam logic [3:0] S_IDLE    = 4'd0;
	localparam logic [3:0] S_UP_CALC = 4'd1;
	localparam logic [3:0] S_UP_DIV  = 4'd2;
	localparam logic [3:0] S_UP_CMP  = 4'd3;
	localparam logic [3:0] S_EX_R0   = 4'd4;
	localparam logic [3:0] S_EX_R1   = 4'd5;
	localparam logic [3:0] S_EX_RL   = 4'd6;
	localparam logic [3:0] S_DN_CALC = 4'd7;
	localparam logic [3:0] S_DN_CHK  = 4'd8;
	localparam logic [3:0] S_DN_SCAN = 4'd9;
	localparam logic [3:0] S_DN_DEC  = 4'd10;
	localparam logic [3:0] S_FIN     = 4'd11;

endpackage

### rtl/core/dary_min_heap_queue_unit.sv
// Top level of the d-ary min-heap priority queue: sequencer, heap memory and
// result register. Depends on dmhq_pkg.
//
// An insert climbs from the new leaf, one parent read and compare per level,
// and writes the entry where it stops, at the root or below; an extract reads
// the root and the last entry, then per level reads the children one by one and
// moves the smallest up while it beats the entry, until the entry comes to rest.
// A dropped insert or an empty extract skips the heap. The next beat is taken the
// cycle after the result is loaded; the single memory read port sets the pace.
// Reset (arst_n low, asynchronous) empties the queue and sets the arity to 2.
module dary_min_heap_queue_unit #(
	parameter int CAPACITY  = 256,
	parameter int MAX_ARITY = 8
) (
	input  logic        clk,
	input  logic        arst_n,
	// Configuration: arity in bits 3:0.
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [3:0]  cfg_data,
	// Input beat.
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [47:0] s_tdata,   // tag [15:0], priority_req [47:16]
	input  logic        s_tuser,   // action: 0 insert, 1 extract minimum
	// Result beat.
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata,   // out_tag [15:0], out_priority [47:16],
	                               // occupancy [56:48], zero above
	output logic [1:0]  m_tuser    // status
);

	localparam int IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int FW = IW + 5;
	localparam int PW = IW + 21;

	// Heap memory, one write and one registered read per cycle.
	dmhq_pkg::entry_t mem [CAPACITY];
	dmhq_pkg::entry_t rd_q;
	logic [IW-1:0]    raddr;
	logic             we;
	logic [IW-1:0]    waddr;
	dmhq_pkg::entry_t wdata;

	logic [3:0]       state_q;
	logic [CW-1:0]    count_q;
	logic [IW-1:0]    pos_q;
	dmhq_pkg::entry_t cur_q;
	dmhq_pkg::entry_t best_q;
	logic [IW-1:0]    best_idx_q;
	logic [4:0]       k_q;
	logic [FW-1:0]    first_q;
	logic [PW-1:0]    prod_q;
	logic [3:0]       arity_q;

	logic [15:0]        res_tag_q;
	logic signed [31:0] res_key_q;
	logic [1:0]         res_st_q;
	logic               out_valid_q;
	logic [15:0]        out_tag_q;
	logic signed [31:0] out_key_q;
	logic [1:0]         out_st_q;
	logic [CW-1:0]      out_cnt_q;

	logic [4:0]    eff_d;
	logic [IW-1:0] parent;
	logic [FW-1:0] cur_idx;
	logic [FW-1:0] next_idx;
	logic [FW-1:0] count_ext;
	logic [31:0]   occ_ext;

	always_comb begin
		if (arity_q < 4'd2) begin
			eff_d = 5'd2;
		end else if (32'(arity_q) > MAX_ARITY) begin
			eff_d = 5'(MAX_ARITY);
		end else begin
			eff_d = {1'b0, arity_q};
		end
	end

	assign parent    = IW'(prod_q >> dmhq_pkg::RECIP_SHIFT);
	assign cur_idx   = first_q + FW'(k_q);
	assign next_idx  = cur_idx + FW'(1);
	assign count_ext = FW'(count_q);

	assign cfg_ready = 1'b1;
	assign s_tready  = (state_q == dmhq_pkg::S_IDLE);
	assign m_tvalid  = out_valid_q;
	assign occ_ext   = 32'(out_cnt_q);
	assign m_tdata   = {7'd0, occ_ext[8:0], out_key_q, out_tag_q};
	assign m_tuser   = out_st_q;

	// Read address and the memory write for the current step.
	always_comb begin
		raddr = '0;
		we    = 1'b0;
		waddr = pos_q;
		wdata = cur_q;
		unique case (state_q)
			dmhq_pkg::S_UP_CALC: begin
				we = (pos_q == '0);
			end
			dmhq_pkg::S_UP_DIV: begin
				raddr = parent;
			end
			dmhq_pkg::S_UP_CMP: begin
				// The hole sits at the child slot held in best_idx_q.
				we    = 1'b1;
				waddr = best_idx_q;
				if (dmhq_pkg::key_less(cur_q.key, rd_q.key)) begin
					wdata = rd_q;
				end
			end
			dmhq_pkg::S_EX_R1: begin
				raddr = IW'(count_q - CW'(1));
			end
			dmhq_pkg::S_DN_CHK: begin
				raddr = IW'(first_q);
				we    = (first_q >= count_ext);
			end
			dmhq_pkg::S_DN_SCAN: begin
				raddr = IW'(next_idx);
			end
			dmhq_pkg::S_DN_DEC: begin
				we = 1'b1;
				if (dmhq_pkg::key_less(best_q.key, cur_q.key)) begin
					wdata = best_q;
				end
			end
			default: begin
				raddr = '0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rd_q <= mem[raddr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= dmhq_pkg::S_IDLE;
			count_q     <= '0;
			arity_q     <= 4'd2;
			out_valid_q <= 1'b0;
			pos_q       <= '0;
			cur_q       <= '0;
			best_q      <= '0;
			best_idx_q  <= '0;
			k_q         <= '0;
			first_q     <= '0;
			prod_q      <= '0;
			res_tag_q   <= '0;
			res_key_q   <= '0;
			res_st_q    <= dmhq_pkg::ST_DONE;
			out_tag_q   <= '0;
			out_key_q   <= '0;
			out_st_q    <= dmhq_pkg::ST_DONE;
			out_cnt_q   <= '0;
		end else begin
			if (cfg_valid) begin
				arity_q <= cfg_data;
			end
			// The finishing step reloads the result register itself.
			if (out_valid_q && m_tready && state_q != dmhq_pkg::S_FIN) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				dmhq_pkg::S_IDLE: begin
					if (s_tvalid) begin
						res_tag_q <= '0;
						res_key_q <= '0;
						res_st_q  <= dmhq_pkg::ST_DONE;
						if (!s_tuser) begin
							if (32'(count_q) >= CAPACITY) begin
								res_st_q <= dmhq_pkg::ST_FULL;
								state_q  <= dmhq_pkg::S_FIN;
							end else begin
								cur_q   <= '{tag: s_tdata[15:0], key: s_tdata[47:16]};
								pos_q   <= IW'(count_q);
								count_q <= count_q + CW'(1);
								state_q <= dmhq_pkg::S_UP_CALC;
							end
						end else if (count_q == '0) begin
							res_st_q  <= dmhq_pkg::ST_EMPTY;
							res_key_q <= dmhq_pkg::KEY_MAX;
							state_q   <= dmhq_pkg::S_FIN;
						end else begin
							state_q <= dmhq_pkg::S_EX_R0;
						end
					end
				end
				dmhq_pkg::S_UP_CALC: begin
					prod_q  <= PW'((pos_q - IW'(1)) * dmhq_pkg::arity_recip(eff_d));
					state_q <= (pos_q == '0) ? dmhq_pkg::S_FIN : dmhq_pkg::S_UP_DIV;
				end
				dmhq_pkg::S_UP_DIV: begin
					pos_q   <= parent;
					best_idx_q <= pos_q;
					state_q <= dmhq_pkg::S_UP_CMP;
				end
				dmhq_pkg::S_UP_CMP: begin
					// pos_q already holds the parent; the hole moves up on a swap.
					if (dmhq_pkg::key_less(cur_q.key, rd_q.key)) begin
						state_q <= dmhq_pkg::S_UP_CALC;
					end else begin
						state_q <= dmhq_pkg::S_FIN;
					end
				end
				dmhq_pkg::S_EX_R0: begin
					state_q <= dmhq_pkg::S_EX_R1;
				end
				dmhq_pkg::S_EX_R1: begin
					res_tag_q <= rd_q.tag;
					res_key_q <= rd_q.key;
					state_q   <= dmhq_pkg::S_EX_RL;
				end
				dmhq_pkg::S_EX_RL: begin
					cur_q   <= rd_q;
					count_q <= count_q - CW'(1);
					pos_q   <= '0;
					state_q <= dmhq_pkg::S_DN_CALC;
				end
				dmhq_pkg::S_DN_CALC: begin
					first_q <= FW'(eff_d * pos_q) + FW'(1);
					k_q     <= '0;
					state_q <= dmhq_pkg::S_DN_CHK;
				end
				dmhq_pkg::S_DN_CHK: begin
					state_q <= (first_q >= count_ext) ? dmhq_pkg::S_FIN
					                                  : dmhq_pkg::S_DN_SCAN;
				end
				dmhq_pkg::S_DN_SCAN: begin
					if (k_q == '0 || dmhq_pkg::key_less(rd_q.key, best_q.key)) begin
						best_q     <= rd_q;
						best_idx_q <= IW'(cur_idx);
					end
					if ((k_q + 5'd1) < eff_d && next_idx < count_ext) begin
						k_q <= k_q + 5'd1;
					end else begin
						state_q <= dmhq_pkg::S_DN_DEC;
					end
				end
				dmhq_pkg::S_DN_DEC: begin
					if (dmhq_pkg::key_less(best_q.key, cur_q.key)) begin
						pos_q   <= best_idx_q;
						state_q <= dmhq_pkg::S_DN_CALC;
					end else begin
						state_q <= dmhq_pkg::S_FIN;
					end
				end
				dmhq_pkg::S_FIN: begin
					if (!out_valid_q || m_tready) begin
						out_valid_q <= 1'b1;
						out_tag_q   <= res_tag_q;
						out_key_q   <= res_key_q;
						out_st_q    <= res_st_q;
						out_cnt_q   <= count_q;
						state_q     <= dmhq_pkg::S_IDLE;
					end
				end
				default: begin
					state_q <= dmhq_pkg::S_IDLE;
				end
			endcase
		end
	end

`ifndef SYNTHESIS
	// The entry count never exceeds the store.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		32'(count_q) <= CAPACITY)
		else $error("entry count above capacity");

	// During a climb the parent index lies below the count.
	a_up_pos: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == dmhq_pkg::S_UP_CMP) |-> (CW'(pos_q) < count_q))
		else $error("sift-up parent out of range");

	// A result is only published from the finishing step.
	a_publish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q == dmhq_pkg::S_FIN))
		else $error("result published outside finish step");
`endif

endmodule

### tb/tb_dary_min_heap_queue_unit.sv
// Self-checking testbench for the d-ary min-heap queue unit: a heap predictor,
// directed and random insert/extract beats, and random idling. Needs dmhq_pkg.
module tb_dary_min_heap_queue_unit;

	localparam int CAP       = 256;
	localparam int WDOG_MAX  = 20000;
	localparam logic ACT_INS = 1'b0;
	localparam logic ACT_EXT = 1'b1;

	logic        clk;
	logic        arst_n;
	logic        cfg_valid;
	logic        cfg_ready;
	logic [3:0]  cfg_data;
	logic        s_tvalid;
	logic        s_tready;
	logic [47:0] s_tdata;
	logic        s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [63:0] m_tdata;
	logic [1:0]  m_tuser;

	dary_min_heap_queue_unit #(.CAPACITY(CAP), .MAX_ARITY(8)) i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);

	// One expected result beat.
	typedef struct {
		logic [15:0]        tag;
		logic signed [31:0] key;
		logic [1:0]         status;
		logic [8:0]         occupancy;
	} heap_result_t;

	// Directed row: the action, its fields, and optionally a hand-typed result.
	typedef struct {
		logic               act;
		logic [15:0]        tag;
		logic signed [31:0] key;
		bit                 typed;
		heap_result_t       res;
	} heap_row_t;

	// Predictor state: its own copy of the heap and the arity register.
	dmhq_pkg::entry_t shadow_heap [CAP];
	int               shadow_count;
	logic [3:0]       shadow_arity;
	heap_result_t     pending_results[$];
	int               error_count;
	bit               hold_off_req;
	bit               quiet_sink;
	int               idle_cycles;

	function automatic int used_arity();
		if (shadow_arity < 2) return 2;
		if (shadow_arity > 8) return 8;
		return int'(shadow_arity);
	endfunction

	function automatic void swap_slots(int a, int b);
		dmhq_pkg::entry_t t;
		t = shadow_heap[a];
		shadow_heap[a] = shadow_heap[b];
		shadow_heap[b] = t;
	endfunction

	// Applies one operation to the shadow heap and returns the expected beat.
	function automatic heap_result_t heap_predict(logic act, logic [15:0] tag,
	                                              logic signed [31:0] key);
		heap_result_t r;
		int d, pos, up, first, best;
		d = used_arity();
		r.tag = '0;
		r.key = '0;
		r.status = dmhq_pkg::ST_DONE;
		if (act == ACT_INS) begin
			if (shadow_count >= CAP) begin
				r.status = dmhq_pkg::ST_FULL;
			end else begin
				shadow_heap[shadow_count] = '{tag: tag, key: key};
				pos = shadow_count;
				shadow_count++;
				while (pos > 0) begin
					up = (pos - 1) / d;
					if (!($signed(shadow_heap[pos].key) < $signed(shadow_heap[up].key)))
						break;
					swap_slots(pos, up);
					pos = up;
				end
			end
		end else if (shadow_count == 0) begin
			r.status = dmhq_pkg::ST_EMPTY;
			r.key = dmhq_pkg::KEY_MAX;
		end else begin
			r.tag = shadow_heap[0].tag;
			r.key = shadow_heap[0].key;
			shadow_count--;
			shadow_heap[0] = shadow_heap[shadow_count];
			pos = 0;
			forever begin
				first = d * pos + 1;
				if (first >= shadow_count) break;
				best = first;
				for (int k = 1; k < d && first + k < shadow_count; k++)
					if ($signed(shadow_heap[first + k].key) < $signed(shadow_heap[best].key))
						best = first + k;
				if (!($signed(shadow_heap[best].key) < $signed(shadow_heap[pos].key)))
					break;
				swap_slots(pos, best);
				pos = best;
			end
		end
		r.occupancy = shadow_count[8:0];
		return r;
	endfunction

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// Result checker: every accepted beat is compared with the oldest expectation.
	always @(posedge clk) begin
		heap_result_t e;
		if (m_tvalid && m_tready) begin
			if (pending_results.size() == 0) begin
				$error("result beat with nothing expected: %h", m_tdata);
				error_count++;
			end else begin
				e = pending_results.pop_front();
				if (m_tdata[15:0] !== e.tag) begin
					$error("out_tag exp %0d got %0d", e.tag, m_tdata[15:0]);
					error_count++;
				end
				if ($signed(m_tdata[47:16]) !== e.key) begin
					$error("out_priority exp %0d got %0d", e.key, $signed(m_tdata[47:16]));
					error_count++;
				end
				if (m_tuser !== e.status) begin
					$error("status exp %0d got %0d", e.status, m_tuser);
					error_count++;
				end
				if (m_tdata[56:48] !== e.occupancy) begin
					$error("occupancy exp %0d got %0d", e.occupancy, m_tdata[56:48]);
					error_count++;
				end
				if (m_tdata[63:57] !== '0) begin
					$error("m_tdata pad exp 0 got %h", m_tdata[63:57]);
					error_count++;
				end
			end
		end
	end

	// Watchdog: counts cycles in which no beat moves on any channel.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= WDOG_MAX) begin
			$display("tb_dary_min_heap_queue_unit: done, errors");
			$finish;
		end
	end

	// Sink side: random stall bursts, one long hold-off on request, none at the end.
	initial begin
		int n;
		m_tready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				m_tready <= 1'b0;
				for (int i = 0; i < 600; i++) @(negedge clk);
				hold_off_req = 0;
				m_tready <= 1'b1;
			end else if (!quiet_sink && $urandom_range(0, 5) == 0) begin
				n = $urandom_range(1, 11);
				m_tready <= 1'b0;
				for (int i = 1; i < n; i++) @(negedge clk);
			end else begin
				m_tready <= 1'b1;
			end
		end
	end

	// Offers one beat at the falling edge, after an optional random idle gap, and
	// holds it until it is accepted. The valid stays high on return so that a
	// following beat can go out at once; whoever stops sending drops it.
	task automatic send_op(logic act, logic [15:0] tag, logic signed [31:0] key,
	                       bit gaps);
		int n;
		if (gaps && $urandom_range(0, 4) == 0) begin
			n = $urandom_range(1, 11);
			s_tvalid <= 1'b0;
			repeat (n) @(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= act;
		s_tdata  <= {key, tag};
		pending_results.push_back(heap_predict(act, tag, key));
		do @(posedge clk); while (!(s_tvalid && s_tready));
		@(negedge clk);
	endtask

	// Arity changes happen only with nothing outstanding.
	task automatic write_arity(logic [3:0] value);
		s_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(negedge clk);
		repeat (10) @(negedge clk);
		cfg_valid <= 1'b1;
		cfg_data  <= value;
		do @(posedge clk); while (!cfg_ready);
		@(negedge clk);
		cfg_valid <= 1'b0;
		shadow_arity = value;
	endtask

	// Well-formed random keys drawn from a few bands so that ties, extremes and
	// sign changes all show up.
	function automatic logic signed [31:0] rand_key();
		case ($urandom_range(0, 4))
			0: return $signed($urandom());
			1: return $signed($urandom_range(0, 7)) - 4;
			2: return $urandom_range(0, 1) ? dmhq_pkg::KEY_MAX : 32'sh8000_0000;
			default: return $signed($urandom_range(0, 2000)) - 1000;
		endcase
	endfunction

	heap_row_t directed[$];
	logic [3:0] arity_plan[8] = '{4'd3, 4'd8, 4'd0, 4'd15, 4'd5, 4'd2, 4'd1, 4'd4};

	initial begin
		heap_result_t r0;
		heap_result_t pred;
		int fill_n;
		error_count = 0;
		hold_off_req = 0;
		quiet_sink = 0;
		idle_cycles = 0;
		shadow_count = 0;
		shadow_arity = 4'd2;
		arst_n = 1'b0;
		cfg_valid = 1'b0;
		cfg_data = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = ACT_INS;
		repeat (7) @(negedge clk);
		arst_n = 1'b1;

		// Directed rows go to the predictor; typed rows also check its result.
		r0 = '{tag: 16'd0, key: dmhq_pkg::KEY_MAX, status: dmhq_pkg::ST_EMPTY,
		       occupancy: 9'd0};
		directed.push_back('{ACT_EXT, 16'hFFFF, 32'sd5, 1, r0});
		directed.push_back('{ACT_INS, 16'hFFFF, dmhq_pkg::KEY_MAX, 1,
			'{16'd0, 32'sd0, dmhq_pkg::ST_DONE, 9'd1}});
		directed.push_back('{ACT_EXT, 16'd0, 32'sd0, 1,
			'{16'hFFFF, dmhq_pkg::KEY_MAX, dmhq_pkg::ST_DONE, 9'd0}});
		directed.push_back('{ACT_EXT, 16'd0, 32'sd0, 1, r0});
		directed.push_back('{ACT_INS, 16'h0001, 32'sh8000_0000, 0, r0});
		directed.push_back('{ACT_INS, 16'h0002, 32'sd7, 0, r0});
		directed.push_back('{ACT_INS, 16'h0003, 32'sd7, 0, r0});   // tie with previous
		directed.push_back('{ACT_INS, 16'h0004, -32'sd1, 0, r0});
		directed.push_back('{ACT_INS, 16'h0005, 32'sd7, 0, r0});
		directed.push_back('{ACT_INS, 16'hA5A5, 32'sh5A5A_5A5A, 0, r0});
		directed.push_back('{ACT_INS, 16'h5A5A, 32'shA5A5_A5A5, 0, r0});
		for (int i = 0; i < 8; i++)
			directed.push_back('{ACT_EXT, 16'd0, 32'sd0, 0, r0});
		foreach (directed[i]) begin
			send_op(directed[i].act, directed[i].tag, directed[i].key, 0);
			if (directed[i].typed) begin
				pred = pending_results[$];
				if (pred.tag !== directed[i].res.tag || pred.key !== directed[i].res.key ||
				    pred.status !== directed[i].res.status ||
				    pred.occupancy !== directed[i].res.occupancy) begin
					$error("directed row %0d: typed tag/key/status/occupancy %0d/%0d/%0d/%0d got %0d/%0d/%0d/%0d",
						i, directed[i].res.tag, directed[i].res.key, directed[i].res.status,
						directed[i].res.occupancy, pred.tag, pred.key, pred.status,
						pred.occupancy);
					error_count++;
				end
			end
		end

		// Fill to capacity with arity 2, overflow, drain past empty.
		for (int i = 0; i < CAP + 3; i++)
			send_op(ACT_INS, 16'($urandom()), rand_key(), 1);
		for (int i = 0; i < CAP + 2; i++)
			send_op(ACT_EXT, 16'd0, 32'sd0, 1);

		// Random phases over several arity settings, heap left partly full between.
		foreach (arity_plan[p]) begin
			write_arity(arity_plan[p]);
			if (p == 2) hold_off_req = 1;   // sink holds off, source keeps offering
			if (p == 7) quiet_sink = 1;
			for (int i = 0; i < 55; i++) begin
				if ($urandom_range(0, 99) < (shadow_count < 40 ? 65 : 45))
					send_op(ACT_INS, 16'($urandom()), rand_key(), !quiet_sink);
				else
					send_op(ACT_EXT, 16'($urandom()), $signed($urandom()), !quiet_sink);
			end
		end
		// Fill once more at maximum arity to reach the full store with a wide tree.
		write_arity(4'd8);
		fill_n = CAP + 2 - shadow_count;
		for (int i = 0; i < fill_n; i++)
			send_op(ACT_INS, 16'($urandom()), rand_key(), 0);
		while (shadow_count > 0) send_op(ACT_EXT, 16'd0, 32'sd0, 0);
		s_tvalid <= 1'b0;

		while (pending_results.size() != 0) @(negedge clk);
		repeat (200) @(negedge clk);
		if (error_count == 0 && pending_results.size() == 0)
			$display("tb_dary_min_heap_queue_unit: done, clean");
		else
			$display("tb_dary_min_heap_queue_unit: done, errors");
		$finish;
	end

endmodule
